[rtl/msqwt_pkg.sv]
// Shared types and constants for the multi-server queue wait tracker.
`default_nettype none

package msqwt_pkg;

  localparam int ARRIVAL_W = 16;
  localparam int SERVICE_W = 8;
  localparam int WAIT_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int NS_W      = 5;
  localparam int THR_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_SERVERS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_THRESHOLD = 1'b1;

  localparam logic [NS_W-1:0]  NUM_SERVERS_RESET    = 5'd1;
  localparam logic [THR_W-1:0] WAIT_THRESHOLD_RESET = 16'd10;

  typedef struct packed {
    logic [WAIT_W-1:0] wait_time;
    logic              waited_long;
  } job_res_t;

endpackage

`default_nettype wire

[rtl/msqwt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module msqwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/msqwt_sort.sv]
// Busy-until list sequencer: head lookup, wait/finish math, one bubble pass.
`default_nettype none

module msqwt_sort
  import msqwt_pkg::*;
#(
  parameter int MAX_SERVERS = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [ARRIVAL_W-1:0] arrival_time,
  input  wire logic [SERVICE_W-1:0] service_time,
  input  wire logic [NS_W-1:0]      num_servers,
  input  wire logic [THR_W-1:0]     wait_threshold,
  output logic                      idle,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output job_res_t                  res
);

  localparam int ADDR_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HEAD  = 5'b00010,
    S_CALC  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_LAST  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [ARRIVAL_W-1:0] arrival_q;
  logic [SERVICE_W-1:0] service_q;
  logic [ADDR_W-1:0]    last_q, last_calc;
  logic [ADDR_W-1:0]    j_q, jp1, jp2;
  logic [TIME_BITS-1:0] head_q, carry;
  logic [MAX_SERVERS-1:0] vld;
  logic                 rd_vld;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [TIME_BITS-1:0] ram_wdata, ram_rdata, rd_data;

  logic [TIME_BITS-1:0] arr_ext, start_t, wait_full, finish, lo, hi;
  logic [TIME_BITS:0]   fin_sum;
  logic [WAIT_W-1:0]    wait32;
  logic                 late, is_long;

  msqwt_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_SERVERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero (servers free since reset)
  assign rd_data = rd_vld ? ram_rdata : '0;

  always_comb begin
    if (num_servers == '0) begin
      last_calc = '0;
    end else if (int'(num_servers) > MAX_SERVERS) begin
      last_calc = ADDR_W'(MAX_SERVERS - 1);
    end else begin
      last_calc = ADDR_W'(num_servers - NS_W'(1));
    end
  end

  assign arr_ext   = TIME_BITS'(arrival_q);
  assign late      = head_q > arr_ext;
  assign start_t   = late ? head_q : arr_ext;
  assign wait_full = late ? (head_q - arr_ext) : '0;
  assign fin_sum   = {1'b0, start_t} + (TIME_BITS + 1)'(service_q);
  assign finish    = fin_sum[TIME_BITS] ? '1 : fin_sum[TIME_BITS-1:0];
  assign is_long   = wait_full > TIME_BITS'(wait_threshold);

  generate
    if (TIME_BITS > WAIT_W) begin : g_wait_sat
      assign wait32 = (|wait_full[TIME_BITS-1:WAIT_W]) ? '1 : wait_full[WAIT_W-1:0];
    end else begin : g_wait_ext
      assign wait32 = WAIT_W'(wait_full);
    end
  endgenerate

  // carry holds the largest value seen so far in the pass
  assign lo  = (carry <= rd_data) ? carry : rd_data;
  assign hi  = (carry <= rd_data) ? rd_data : carry;
  assign jp1 = j_q + ADDR_W'(1);
  assign jp2 = j_q + ADDR_W'(2);

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = carry;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ram_re     = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        state_next = S_CALC;
      end
      S_CALC: begin
        if (last_q == '0) begin
          state_next = S_LAST;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = ADDR_W'(1);
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = lo;
        if (jp1 == last_q) begin
          state_next = S_LAST;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = jp2;
        end
      end
      S_LAST: begin
        ram_we    = res_ready;
        ram_waddr = last_q;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld <= vld[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          arrival_q <= arrival_time;
          service_q <= service_time;
          last_q    <= last_calc;
        end
      end
      S_HEAD: begin
        head_q <= rd_data;
      end
      S_CALC: begin
        carry           <= finish;
        res.wait_time   <= wait32;
        res.waited_long <= is_long;
        j_q             <= '0;
      end
      S_SWEEP: begin
        carry <= hi;
        j_q   <= jp1;
      end
      S_LAST: begin
      end
      default: begin
      end
    endcase
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_LAST);

endmodule

`default_nettype wire

[rtl/msqwt_stats.sv]
// Saturating wait statistics and the output register stage.
`default_nettype none

module msqwt_stats
  import msqwt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               res_valid,
  output logic                    res_ready,
  input  wire job_res_t           res,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [WAIT_W-1:0]       wait_time,
  output logic                    waited_long,
  output logic [WAIT_W-1:0]       total_wait,
  output logic [COUNT_W-1:0]      long_count,
  output logic [COUNT_W-1:0]      served_count
);

  logic              take;
  logic [WAIT_W:0]   sum_wide;
  logic [WAIT_W-1:0] sum_next;

  assign res_ready = !out_valid || out_ready;
  assign take      = res_valid && res_ready;
  assign sum_wide  = {1'b0, total_wait} + {1'b0, res.wait_time};
  assign sum_next  = sum_wide[WAIT_W] ? '1 : sum_wide[WAIT_W-1:0];

  // counters double as the output fields; they change only on a new beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      total_wait   <= '0;
      long_count   <= '0;
      served_count <= '0;
    end else begin
      if (take) begin
        out_valid  <= 1'b1;
        total_wait <= sum_next;
        if (res.waited_long && (long_count != '1)) begin
          long_count <= long_count + COUNT_W'(1);
        end
        if (served_count != '1) begin
          served_count <= served_count + COUNT_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wait_time   <= res.wait_time;
      waited_long <= res.waited_long;
    end
  end

endmodule

`default_nettype wire

[rtl/multi_server_queue_wait_tracker_top.sv]
// Multi-server queue wait tracker, top level.
//
// Jobs come in on the in channel (arrival_time, service_time), one beat per
// job, and leave as one result beat on the out channel: the job's wait, its
// long-wait flag, and the running total wait, long-wait count and job count.
// The cfg channel writes num_servers (index 0) and wait_threshold (index 1);
// it is always ready and is meant to be used while no job is in flight.
// Busy-until times live in a RAM sorted ascending; each job reads the head,
// then makes one compare-and-swap pass over the active entries, one entry
// per cycle through the RAM's single read and write port.
// Steps per job: head read, wait/finish math, the pass over n entries, where n
// is the active server count (1..MAX_SERVERS), then a last step that hands the
// result on. in_ready is high only between jobs.
// A result waiting at the output does not block the next job; if the
// receiver stalls, a finished job holds in its last step until the output
// register frees up.
// Reset clears the counters and returns the config to its reset values; the list reads as all zero through
// per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module multi_server_queue_wait_tracker_top
  import msqwt_pkg::*;
#(
  parameter int MAX_SERVERS = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ARRIVAL_W-1:0]  arrival_time,
  input  wire logic [SERVICE_W-1:0]  service_time,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [WAIT_W-1:0]          wait_time,
  output logic                       waited_long,
  output logic [WAIT_W-1:0]          total_wait,
  output logic [COUNT_W-1:0]         long_count,
  output logic [COUNT_W-1:0]         served_count,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [NS_W-1:0]  num_servers;
  logic [THR_W-1:0] wait_threshold;
  logic             idle, res_valid, res_ready;
  job_res_t         res;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers    <= NUM_SERVERS_RESET;
      wait_threshold <= WAIT_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_SERVERS:    num_servers    <= cfg_data[NS_W-1:0];
        REG_WAIT_THRESHOLD: wait_threshold <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  msqwt_sort #(.MAX_SERVERS(MAX_SERVERS), .TIME_BITS(TIME_BITS)) u_sort (
    .clk            (clk),
    .rst            (rst),
    .start          (in_valid && in_ready),
    .arrival_time   (arrival_time),
    .service_time   (service_time),
    .num_servers    (num_servers),
    .wait_threshold (wait_threshold),
    .idle           (idle),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  msqwt_stats u_stats (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .wait_time    (wait_time),
    .waited_long  (waited_long),
    .total_wait   (total_wait),
    .long_count   (long_count),
    .served_count (served_count)
  );

endmodule

`default_nettype wire

[rtl/msqwt_checker.sv]
// Port-level checks for the queue wait tracker, bound to the top level.
`default_nettype none

module msqwt_checker
  import msqwt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [WAIT_W-1:0]     wait_time,
  input wire logic                  waited_long,
  input wire logic [WAIT_W-1:0]     total_wait,
  input wire logic [COUNT_W-1:0]    long_count,
  input wire logic [COUNT_W-1:0]    served_count
);

  // one job at a time: no second beat right after an accepted one
  a_one_job: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(wait_time) && $stable(total_wait))
    else $error("stalled result changed");

  a_long_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && waited_long |-> wait_time != '0)
    else $error("long wait flagged with zero wait");

  a_sum_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> total_wait >= wait_time)
    else $error("total wait below this job's wait");

  a_long_le_served: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> long_count <= served_count)
    else $error("more long waits than jobs");

endmodule

bind multi_server_queue_wait_tracker_top msqwt_checker u_msqwt_checker (.*);

`default_nettype wire
